// ----- rtl/lps_pkg.sv -----
// Shared types, codes and the pattern ROM of the LED pattern sequencer.
package lps_pkg;

  localparam int MaxSteps = 9;
  localparam int TickBits = 10;
  localparam int IdxBits  = 4;

  localparam logic [TickBits-1:0] TickMax = 10'd1023;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [1:0] LED_GREEN  = 2'd0;
  localparam logic [1:0] LED_YELLOW = 2'd1;
  localparam logic [1:0] LED_RED    = 2'd2;
  localparam logic [1:0] LED_CHOSEN = 2'd3;

  localparam logic [1:0] PAT_VOTE_GREEN  = 2'd0;
  localparam logic [1:0] PAT_VOTE_CHOSEN = 2'd1;
  localparam logic [1:0] PAT_INPUT_ERR   = 2'd2;
  localparam logic [1:0] PAT_INIT        = 2'd3;

  typedef struct packed {
    logic       op;
    logic [1:0] pattern;
    logic [1:0] led_select;
  } lps_cmd_t;

  typedef struct packed {
    logic [2:0]         leds;
    logic               busy_res;
    logic [IdxBits-1:0] step_number;
  } lps_res_t;

  typedef struct packed {
    logic [1:0]          led;
    logic [TickBits-1:0] on_ticks;
    logic [TickBits-1:0] off_ticks;
  } lps_step_t;

  function automatic lps_step_t mk_step(logic [1:0] led, logic [TickBits-1:0] on_t,
                                        logic [TickBits-1:0] off_t);
    lps_step_t s;
    s.led       = led;
    s.on_ticks  = on_t;
    s.off_ticks = off_t;
    return s;
  endfunction

  function automatic logic [IdxBits-1:0] pat_len(logic [1:0] pat);
    logic [IdxBits-1:0] n;
    unique case (pat)
      PAT_VOTE_GREEN:  n = 4'd4;
      PAT_VOTE_CHOSEN: n = 4'd4;
      PAT_INPUT_ERR:   n = 4'd3;
      default:         n = 4'd9;
    endcase
    return n;
  endfunction

  // idx is clamped by the caller to MaxSteps-1
  function automatic lps_step_t step_rom(logic [1:0] pat, logic [IdxBits-1:0] idx);
    lps_step_t s;
    s = mk_step(LED_GREEN, 10'd0, 10'd0);
    unique case (pat)
      PAT_VOTE_GREEN: begin
        case (idx)
          4'd0, 4'd1, 4'd2: s = mk_step(LED_GREEN, 10'd100, 10'd100);
          4'd3:             s = mk_step(LED_GREEN, 10'd500, 10'd100);
          default:          s = mk_step(LED_GREEN, 10'd0, 10'd0);
        endcase
      end
      PAT_VOTE_CHOSEN: begin
        case (idx)
          4'd0, 4'd1, 4'd2: s = mk_step(LED_CHOSEN, 10'd100, 10'd100);
          4'd3:             s = mk_step(LED_CHOSEN, 10'd300, 10'd100);
          default:          s = mk_step(LED_GREEN, 10'd0, 10'd0);
        endcase
      end
      PAT_INPUT_ERR: begin
        case (idx)
          4'd0:    s = mk_step(LED_RED, 10'd100, 10'd100);
          4'd1:    s = mk_step(LED_YELLOW, 10'd100, 10'd100);
          4'd2:    s = mk_step(LED_GREEN, 10'd100, 10'd100);
          default: s = mk_step(LED_GREEN, 10'd0, 10'd0);
        endcase
      end
      default: begin
        case (idx)
          4'd0, 4'd4: s = mk_step(LED_RED, 10'd100, 10'd100);
          4'd1, 4'd3,
          4'd5:       s = mk_step(LED_YELLOW, 10'd100, 10'd100);
          4'd2, 4'd6: s = mk_step(LED_GREEN, 10'd100, 10'd100);
          4'd7:       s = mk_step(LED_GREEN, 10'd200, 10'd200);
          4'd8:       s = mk_step(LED_GREEN, 10'd300, 10'd100);
          default:    s = mk_step(LED_GREEN, 10'd0, 10'd0);
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic logic [IdxBits-1:0] clamp_idx(logic [IdxBits-1:0] idx);
    return (idx >= IdxBits'(MaxSteps)) ? IdxBits'(MaxSteps - 1) : idx;
  endfunction

  function automatic logic [2:0] led_mask(logic [1:0] led, logic [1:0] chosen);
    logic [1:0] l;
    l = (led == LED_CHOSEN) ? chosen : led;
    if (l > LED_RED) l = LED_RED;
    return 3'(3'b001 << l);
  endfunction

endpackage

// ----- rtl/lps_in_stage.sv -----
// Input register stage: holds one accepted command item for the engine.
module lps_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  lps_pkg::lps_cmd_t cmd,
  output logic              item_valid,
  output lps_pkg::lps_cmd_t item,
  input  logic              item_take
);

  logic              held;
  lps_pkg::lps_cmd_t data;

  assign cmd_ready  = !held || item_take;
  assign item_valid = held;
  assign item       = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (cmd_ready) begin
      held <= cmd_valid;
    end
    if (cmd_ready && cmd_valid) begin
      data <= cmd;
    end
  end

endmodule

// ----- rtl/lps_engine.sv -----
// Sequencer state, step timing logic and the result register.
module lps_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  lps_pkg::lps_cmd_t item,
  output logic              item_take,
  output logic              res_valid,
  input  logic              res_ready,
  output lps_pkg::lps_res_t res
);

  localparam int TB = lps_pkg::TickBits;
  localparam int IB = lps_pkg::IdxBits;

  logic          active, active_next;
  logic [1:0]    cur_pattern, cur_pattern_next;
  logic [1:0]    chosen_led, chosen_led_next;
  logic [IB-1:0] step_index, step_index_next;
  logic [TB-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [2:0]    led_drive, led_drive_next;

  lps_pkg::lps_step_t cur_step, nxt_step, first_step;
  logic [IB-1:0]      idx_inc;
  logic [TB:0]        on_t, total_t;
  logic [TB-1:0]      elapsed_inc;
  logic [1:0]         sel_sat;
  lps_pkg::lps_res_t  res_next;

  assign item_take = item_valid && (!res_valid || res_ready);

  always_comb begin
    idx_inc     = step_index + 1'b1;
    cur_step    = lps_pkg::step_rom(cur_pattern, lps_pkg::clamp_idx(step_index));
    nxt_step    = lps_pkg::step_rom(cur_pattern, lps_pkg::clamp_idx(idx_inc));
    first_step  = lps_pkg::step_rom(item.pattern, '0);
    sel_sat     = (item.led_select > lps_pkg::LED_RED) ? lps_pkg::LED_RED : item.led_select;
    on_t        = {1'b0, cur_step.on_ticks};
    total_t     = on_t + {1'b0, cur_step.off_ticks};
    elapsed_inc = (elapsed_ticks < lps_pkg::TickMax) ? elapsed_ticks + 1'b1 : elapsed_ticks;

    active_next        = active;
    cur_pattern_next   = cur_pattern;
    chosen_led_next    = chosen_led;
    step_index_next    = step_index;
    elapsed_ticks_next = elapsed_ticks;
    led_drive_next     = led_drive;

    if (item.op == lps_pkg::OP_START) begin
      active_next        = 1'b1;
      cur_pattern_next   = item.pattern;
      chosen_led_next    = sel_sat;
      step_index_next    = '0;
      elapsed_ticks_next = '0;
      led_drive_next     = lps_pkg::led_mask(first_step.led, sel_sat);
    end else if (active) begin
      elapsed_ticks_next = elapsed_inc;
      if ({1'b0, elapsed_inc} > total_t) begin
        elapsed_ticks_next = '0;
        if (idx_inc >= lps_pkg::pat_len(cur_pattern)) begin
          active_next     = 1'b0;
          step_index_next = '0;
        end else begin
          step_index_next = idx_inc;
          led_drive_next  = led_drive | lps_pkg::led_mask(nxt_step.led, chosen_led);
        end
      end else if ({1'b0, elapsed_inc} > on_t) begin
        led_drive_next = led_drive & ~lps_pkg::led_mask(cur_step.led, chosen_led);
      end
    end

    res_next.leds        = led_drive_next;
    res_next.busy_res    = active_next;
    res_next.step_number = active_next ? step_index_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      cur_pattern   <= '0;
      chosen_led    <= '0;
      step_index    <= '0;
      elapsed_ticks <= '0;
      led_drive     <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (item_take) begin
        active        <= active_next;
        cur_pattern   <= cur_pattern_next;
        chosen_led    <= chosen_led_next;
        step_index    <= step_index_next;
        elapsed_ticks <= elapsed_ticks_next;
        led_drive     <= led_drive_next;
        res_valid     <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    if (item_take) begin
      res <= res_next;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    active |-> step_index < lps_pkg::pat_len(cur_pattern))
    else $error("step index past end of pattern");

  a_idle_idx_zero: assert property (@(posedge clk) disable iff (rst)
    !active |-> step_index == '0 && elapsed_ticks == '0)
    else $error("idle with nonzero step state");

  a_one_led: assert property (@(posedge clk) disable iff (rst)
    $onehot0(led_drive))
    else $error("more than one LED driven");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    item_take |=> res_valid)
    else $error("taken item produced no result");

  a_idle_res: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.busy_res |-> res.step_number == '0)
    else $error("idle result with nonzero step number");

endmodule

// ----- rtl/led_pattern_sequencer_core.sv -----
// Top level of the LED pattern sequencer: input stage feeding the step engine.
// A result is registered once the engine takes its item from the input stage.
// Throughput: one item per cycle unless stalled; a single compare/add step update.
// A full result register stalls the input stage only while res_ready is low.
// Reset (rst, synchronous): idle, all LEDs off, both pipeline stages empty.
module led_pattern_sequencer_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  lps_pkg::lps_cmd_t cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output lps_pkg::lps_res_t res
);

  logic              item_valid;
  logic              item_take;
  lps_pkg::lps_cmd_t item;

  lps_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  lps_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule
